### sv/stsc_pkg.sv
// ============================================================================
// stsc_pkg : shared types and constants of the subarray target sum counter
// Fixed field widths, stream payload widths and the controller state type.
// ============================================================================
`default_nettype none

package stsc_pkg;

    // Width of prefix sums, the target and the search key magnitude
    localparam int unsigned SUM_W       = 44;
    // Width of the running match count
    localparam int unsigned HITS_W      = 13;
    // Width of the element field on the input stream
    localparam int unsigned ELEM_W      = 32;
    // Stream payload widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 16;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } t_state;

endpackage : stsc_pkg

`default_nettype wire

### sv/subarray_target_sum_counter.sv
// ============================================================================
// subarray_target_sum_counter : count contiguous runs summing to a target
// Stores every prefix sum of the sequence in a synchronous memory and
// binary-searches it for (running sum - target) on each new element it stores.
// ============================================================================
//
// Usage
//   Input stream (i_s_*): one element per transaction, tlast closes a sequence.
//   Output stream (o_m_*): one result per element, in order, tlast copies the
//   input tlast. i_cfg_we writes target_sum; write it only while idle.
//   Each element: an accept step that adds the element, stores the new
//   prefix sum and issues the first read, then the binary-search steps
//   (1 to ceil(log2(n+2)) steps, n elements stored so far, at most 13
//   at MAX_LEN = 4096), then the load of the output register. The single
//   read port of the prefix memory allows one read per step. Once the
//   sequence holds MAX_LEN elements, further elements skip the store and
//   search and go straight to the output load.
//   The next element is accepted as soon as the result has moved to the
//   output register, even if the receiver has not yet taken it.
//   Reset (synchronous, active low) clears the sums, counts and flags and
//   sets target_sum to 1; the prefix memory needs no clearing pass, as
//   entry zero reads as constant zero and only entries written in the
//   current sequence are searched. When the receiver stalls, the result
//   holds in the output register and the block waits before loading the
//   next one.
//
`default_nettype none

module subarray_target_sum_counter #(
    parameter int unsigned MAX_LEN   = 4096,
    parameter int unsigned ELEM_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration: target_sum
    input  wire logic                           i_cfg_we,
    input  wire logic [stsc_pkg::SUM_W-1:0]     i_cfg_wdata,
    // Input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: [31:0] elem_value
    input  wire logic [stsc_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // tlast: last
    input  wire logic                           i_s_tlast,
    // Output stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: [0] match, [13:1] match_count, [14] overflow, [15] zero pad
    output logic [stsc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // tlast: done_res
    output logic                                o_m_tlast
);

    import stsc_pkg::*;

    // Index width of the prefix memory (entries 0..MAX_LEN)
    localparam int unsigned AW   = $clog2(MAX_LEN + 1);
    // Width of the search bounds (may reach MAX_LEN + 1)
    localparam int unsigned CW   = $clog2(MAX_LEN + 2);
    localparam int unsigned KEEP = (ELEM_BITS < ELEM_W) ? ELEM_BITS : ELEM_W;
    localparam logic [ELEM_W-1:0] ELEM_MASK = ELEM_W'((64'd1 << KEEP) - 64'd1);

    // Prefix memory and its registered read data
    logic [SUM_W-1:0]        prefix_mem [0:MAX_LEN];
    logic [SUM_W-1:0]        r_rd_data;

    // Control state
    t_state                  r_state,  n_state;
    logic [SUM_W-1:0]        r_target;
    logic [SUM_W-1:0]        r_sum,    n_sum;
    logic [AW-1:0]           r_cnt,    n_cnt;
    logic [HITS_W-1:0]       r_hits,   n_hits;
    logic                    r_ovf,    n_ovf;
    logic                    r_ov;

    // Search and result payload
    logic [CW-1:0]           r_lo,     n_lo;
    logic [CW-1:0]           r_hi,     n_hi;
    logic [AW-1:0]           r_mid,    n_mid;
    logic signed [SUM_W:0]   r_key,    n_key;
    logic                    r_hit,    n_hit;
    logic                    r_last,   n_last;
    logic [OUT_TDATA_W-1:0]  r_out_data;
    logic                    r_out_last;

    // Combinational helpers
    logic [SUM_W-1:0]        w_elem;
    logic [SUM_W-1:0]        w_v;
    logic signed [SUM_W:0]   w_vs;
    logic [CW-1:0]           w_lo;
    logic [CW-1:0]           w_hi;
    logic [CW:0]             w_mid_sum;
    logic                    w_stop;
    logic                    w_wr_en;
    logic                    w_rd_en;
    logic                    w_out_load;

    assign w_elem     = {{(SUM_W - ELEM_W){1'b0}}, i_s_tdata[ELEM_W-1:0] & ELEM_MASK};
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // Next-state logic: accept, search step, output load
    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_hits     = r_hits;
        n_ovf      = r_ovf;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_key      = r_key;
        n_hit      = r_hit;
        n_last     = r_last;
        w_v        = (r_mid == '0) ? '0 : r_rd_data;
        w_vs       = $signed({1'b0, w_v});
        w_lo       = r_lo;
        w_hi       = r_hi;
        w_mid_sum  = '0;
        w_stop     = 1'b0;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_last = i_s_tlast;
                    n_hit  = 1'b0;
                    if (r_ovf || (r_cnt >= AW'(MAX_LEN))) begin
                        // Sequence too long: skip store and search
                        n_ovf   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        // Store the new prefix sum, issue the first probe
                        n_sum   = r_sum + w_elem;
                        n_cnt   = r_cnt + AW'(1);
                        w_wr_en = 1'b1;
                        n_key   = $signed({1'b0, n_sum}) - $signed({1'b0, r_target});
                        n_lo    = '0;
                        n_hi    = CW'(n_cnt);
                        n_mid   = n_cnt >> 1;
                        w_rd_en = 1'b1;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_vs == r_key) begin
                    n_hit   = 1'b1;
                    n_hits  = r_hits + HITS_W'(1);
                    n_state = S_OUT;
                end else begin
                    // Narrow the bounds
                    if (w_vs > r_key) begin
                        if (r_mid == '0) begin
                            w_stop = 1'b1;
                        end else begin
                            w_hi = CW'(r_mid) - CW'(1);
                        end
                    end else begin
                        w_lo = CW'(r_mid) + CW'(1);
                    end
                    if (w_stop || (w_lo > w_hi)) begin
                        n_state = S_OUT;
                    end else begin
                        n_lo      = w_lo;
                        n_hi      = w_hi;
                        w_mid_sum = {1'b0, w_lo} + {1'b0, w_hi};
                        n_mid     = w_mid_sum[AW:1];
                        w_rd_en   = 1'b1;
                    end
                end
            end
            S_OUT: begin
                // Load the output register once it is free
                if (!r_ov || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (r_last) begin
                        n_sum  = '0;
                        n_cnt  = '0;
                        n_hits = '0;
                        n_ovf  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Prefix memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            prefix_mem[n_cnt] <= n_sum;
        end
        if (w_rd_en) begin
            r_rd_data <= prefix_mem[n_mid];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_target <= SUM_W'(1);
            r_sum    <= '0;
            r_cnt    <= '0;
            r_hits   <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_hits  <= n_hits;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_key  <= n_key;
        r_hit  <= n_hit;
        r_last <= n_last;
        if (w_out_load) begin
            r_out_data <= {1'b0, r_ovf, r_hits, r_hit};
            r_out_last <= r_last;
        end
    end

    // Search bounds stay ordered while a probe is outstanding
    a_bounds_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_hi))
        else $error("search bounds crossed while probing");

    // Probes never reach past the newest stored entry
    a_probe_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CW'(r_mid) <= r_hi && r_hi <= CW'(r_cnt)))
        else $error("probe address beyond stored prefix sums");

    // Overflow only once the memory is full
    a_ovf_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == AW'(MAX_LEN)))
        else $error("overflow flag set with memory not full");

    // Closing a sequence clears its state
    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_last) |=> (r_cnt == '0 && r_sum == '0 && r_hits == '0 && !r_ovf))
        else $error("sequence state not cleared after last item");

endmodule : subarray_target_sum_counter

`default_nettype wire

### tb/testbench.sv
// ============================================================================
// testbench : stream-level check of the subarray target sum counter
// A table of directed transactions, then random phases under several
// targets. Each result is checked against the table's expected value or
// an in-bench model of the prefix-sum search, with random gaps on the
// input side and random stalls on the output side.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import stsc_pkg::*;

    localparam int unsigned SEQ_DEPTH   = 4096;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned RAND_ITEMS  = 1400;
    localparam int unsigned EXP_DEPTH   = 16;
    localparam int unsigned DIR_MAX     = 32;
    localparam logic [SUM_W-1:0] TGT_MAX = {SUM_W{1'b1}};
    localparam logic [ELEM_W-1:0] ELEM_MAX = {ELEM_W{1'b1}};

    // Contents of one result transaction
    typedef struct packed {
        logic              match;
        logic [HITS_W-1:0] count;
        logic              ovf;
        logic              done;
    } t_result;

    // One row of the directed table
    typedef struct {
        bit                set_tgt;
        logic [SUM_W-1:0]  tgt;
        logic [ELEM_W-1:0] elem;
        bit                lst;
        bit                typed;
        t_result           want;
    } t_vector;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [SUM_W-1:0]        i_cfg_wdata = '0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                    i_s_tlast   = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    o_m_tlast;

    // Model of the counter
    logic [SUM_W-1:0]  prefix_sums [0:SEQ_DEPTH];
    logic [SUM_W-1:0]  cur_target;
    logic [SUM_W-1:0]  run_sum;
    int unsigned       n_stored;
    logic [HITS_W-1:0] hits;
    logic              seq_ovf;

    // Expected results in order of acceptance, as a ring
    t_result     exp_q [0:EXP_DEPTH-1];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;

    t_vector     dir_rows [0:DIR_MAX-1];
    int unsigned n_rows   = 0;
    bit        calm       = 1'b0;
    int        stall_left = 0;
    int unsigned cycles   = 0;
    int unsigned errors   = 0;
    int unsigned n_sent   = 0;
    int unsigned n_checked = 0;
    int unsigned n_hits   = 0;
    int unsigned n_phases = 0;

    subarray_target_sum_counter #(
        .MAX_LEN   (SEQ_DEPTH),
        .ELEM_BITS (ELEM_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Number of results still outstanding
    function automatic int unsigned exp_level();
        return exp_wr - exp_rd;
    endfunction

    // Append an expected result
    function automatic void exp_put(input t_result r);
        exp_q[exp_wr % EXP_DEPTH] = r;
        exp_wr = exp_wr + 1;
    endfunction

    // Take the oldest expected result
    function automatic t_result exp_take();
        t_result r;
        r = exp_q[exp_rd % EXP_DEPTH];
        exp_rd = exp_rd + 1;
        return r;
    endfunction

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up after a generous number of cycles
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     exp_level());
            $display("status: fail");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stall the receiver at random
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 9) < 3) stall_left <= pick_idle();
        end
    end

    function automatic void clear_sequence();
        prefix_sums[0] = '0;
        run_sum  = '0;
        n_stored = 0;
        hits     = '0;
        seq_ovf  = 1'b0;
    endfunction

    // Binary search of the stored prefix sums 0..top for a signed key
    function automatic bit find_prefix(input int top, input longint key);
        int     lo;
        int     hi;
        int     mid;
        longint v;
        lo = 0;
        hi = top;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            v = longint'({20'd0, prefix_sums[mid]});
            if (v > key) hi = mid - 1;
            else if (v < key) lo = mid + 1;
            else return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the model by one element and return its result
    function automatic t_result count_runs(input logic [ELEM_W-1:0] v, input bit lst);
        t_result r;
        longint  key;
        r.match = 1'b0;
        if (seq_ovf || n_stored >= SEQ_DEPTH) begin
            seq_ovf = 1'b1;
        end else begin
            run_sum  = run_sum + SUM_W'(v);
            n_stored = n_stored + 1;
            prefix_sums[n_stored] = run_sum;
            key = longint'({20'd0, run_sum}) - longint'({20'd0, cur_target});
            if (find_prefix(n_stored, key)) begin
                r.match = 1'b1;
                hits    = hits + 1'b1;
            end
        end
        r.count = hits;
        r.ovf   = seq_ovf;
        r.done  = lst;
        if (lst) clear_sequence();
        return r;
    endfunction

    // Hold the input until every outstanding result has been taken
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (exp_level() != 0) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [SUM_W-1:0] t);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_target   = t;
    endtask

    // Offer one element and record its expected result on acceptance
    task automatic send_elem(input logic [ELEM_W-1:0] v, input bit lst,
                             input bit typed, input t_result want);
        int      gap;
        t_result r;
        gap = pick_idle();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        r = count_runs(v, lst);
        exp_put(typed ? want : r);
        n_sent = n_sent + 1;
        if (r.match) n_hits = n_hits + 1;
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.match = o_m_tdata[0];
            got.count = o_m_tdata[HITS_W:1];
            got.ovf   = o_m_tdata[HITS_W+1];
            got.done  = o_m_tlast;
            if (exp_level() == 0) begin
                errors <= errors + 1;
                $display({"%0t ns: expected no result, got match=%0b count=%0d ",
                          "ovf=%0b last=%0b"},
                         $time, got.match, got.count, got.ovf, got.done);
            end else begin
                want = exp_take();
                n_checked <= n_checked + 1;
                if (got !== want) begin
                    errors <= errors + 1;
                    $display({"%0t ns: result %0d expected match=%0b count=%0d ",
                              "ovf=%0b last=%0b, got match=%0b count=%0d ovf=%0b last=%0b"},
                             $time, n_checked, want.match, want.count, want.ovf,
                             want.done, got.match, got.count, got.ovf, got.done);
                end
            end
        end
    end

    task automatic add_row(input bit set_tgt, input logic [SUM_W-1:0] tgt,
                           input logic [ELEM_W-1:0] elem, input bit lst, input bit typed,
                           input bit m, input int c, input bit o);
        t_vector row;
        row.set_tgt    = set_tgt;
        row.tgt        = tgt;
        row.elem       = elem;
        row.lst        = lst;
        row.typed      = typed;
        row.want.match = m;
        row.want.count = HITS_W'(c);
        row.want.ovf   = o;
        row.want.done  = lst;
        dir_rows[n_rows] = row;
        n_rows = n_rows + 1;
    endtask

    function automatic logic [ELEM_W-1:0] nonzero(input logic [ELEM_W-1:0] v);
        return (v == '0) ? ELEM_W'(1) : v;
    endfunction

    // One phase of random sequences under a freshly chosen target
    task automatic random_phase();
        int                mode;
        int                budget;
        int                seq_len;
        int                k;
        logic [SUM_W-1:0]  tgt;
        logic [ELEM_W-1:0] a;
        mode = $urandom_range(0, 3);
        case (mode)
            0: tgt = SUM_W'($urandom_range(1, 40));
            1: tgt = SUM_W'($urandom_range(2, ELEM_MAX));
            2: case ($urandom_range(0, 2))
                   0: tgt = SUM_W'(1);
                   1: tgt = TGT_MAX;
                   default: tgt = SUM_W'({$urandom, $urandom}) | SUM_W'(1);
               endcase
            default: tgt = SUM_W'($urandom_range(1, 1000)) << $urandom_range(0, 14);
        endcase
        write_target(tgt);
        calm = ($urandom_range(0, 4) == 0);
        n_phases = n_phases + 1;
        budget = $urandom_range(60, 200);
        while (budget > 0) begin
            case ($urandom_range(0, 19))
                0:       seq_len = 1;
                1, 2, 3: seq_len = $urandom_range(31, 120);
                default: seq_len = $urandom_range(2, 30);
            endcase
            if (seq_len > budget) seq_len = budget;
            budget = budget - seq_len;
            k = 0;
            while (k < seq_len) begin
                // Plant a pair of elements that together make the target
                if (mode == 1 && k + 1 < seq_len && $urandom_range(0, 4) == 0) begin
                    a = ELEM_W'($urandom_range(1, ELEM_W'(tgt - SUM_W'(1))));
                    send_elem(a, 1'b0, 1'b0, '0);
                    send_elem(ELEM_W'(tgt) - a, k + 2 == seq_len, 1'b0, '0);
                    k = k + 2;
                end else begin
                    case (mode)
                        0: a = ELEM_W'($urandom_range(1, 8));
                        1: a = ($urandom_range(0, 9) < 3) ? ELEM_W'(tgt) : nonzero($urandom);
                        2: a = nonzero($urandom);
                        default: a = nonzero($urandom >> $urandom_range(8, 31));
                    endcase
                    send_elem(a, k + 1 == seq_len, 1'b0, '0);
                    k = k + 1;
                end
            end
        end
    endtask

    initial begin
        int unsigned rand_base;

        cur_target = SUM_W'(1);
        clear_sequence();

        // Directed table: reset target, extremes, negative key, length one
        add_row(0, '0,              ELEM_W'(1),     0, 1, 1, 1, 0);
        add_row(0, '0,              ELEM_W'(1),     0, 1, 1, 2, 0);
        add_row(0, '0,              ELEM_MAX,       1, 1, 0, 2, 0);
        add_row(1, TGT_MAX,         ELEM_MAX,       1, 1, 0, 0, 0);
        add_row(1, SUM_W'(ELEM_MAX), ELEM_MAX,      0, 1, 1, 1, 0);
        add_row(0, '0,              ELEM_MAX,       0, 1, 1, 2, 0);
        add_row(0, '0,              ELEM_W'(1),     0, 1, 0, 2, 0);
        add_row(0, '0,              ELEM_MAX - 1,   1, 1, 1, 3, 0);
        add_row(1, SUM_W'(6),       ELEM_W'(1),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(2),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(3),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(4),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(5),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(6),     1, 0, 0, 0, 0);
        add_row(1, SUM_W'(10),      ELEM_W'(1),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(2),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(3),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(4),     1, 0, 0, 0, 0);
        add_row(1, SUM_W'(7),       ELEM_W'(7),     1, 1, 1, 1, 0);
        add_row(1, SUM_W'(1),       ELEM_W'(32'h8000_0000), 0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(1),     0, 0, 0, 0, 0);
        add_row(0, '0,              ELEM_W'(1),     1, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int unsigned k = 0; k < n_rows; k++) begin
            if (dir_rows[k].set_tgt) write_target(dir_rows[k].tgt);
            send_elem(dir_rows[k].elem, dir_rows[k].lst, dir_rows[k].typed,
                      dir_rows[k].want);
        end

        // Random phases, each under its own target
        rand_base = n_sent;
        while (n_sent < rand_base + RAND_ITEMS) random_phase();

        wait_drained();
        repeat (32) @(posedge i_clk);

        $display("covered %0d elements: the directed table and %0d random phases",
                 n_sent, n_phases);
        $display("checked %0d results, %0d of them with a matching run",
                 n_checked, n_hits);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
